@@ hdl/pixel_dark_mode_recolor_defines.svh @@
// assertion macros for the dark mode recolor block
// included by the top level, no other dependencies
`ifndef PIXEL_DARK_MODE_RECOLOR_DEFINES_SVH
`define PIXEL_DARK_MODE_RECOLOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PDMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdmr assertion failed");

// next-cycle implication, disabled during reset
`define PDMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdmr assertion failed");

`endif

@@ hdl/pdmr_pkg.sv @@
// shared constants and types for the dark mode recolor block
// no dependencies
package pdmr_pkg;

    localparam int NUM_STAGES = 4;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_INVERT = 2'd1;
    localparam logic [1:0] MODE_TINT   = 2'd2;
    localparam logic [1:0] MODE_LUMA   = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_PAPER = 2'd1;
    localparam logic [1:0] CFG_INK   = 2'd2;

    localparam logic [23:0] PAPER_RESET = 24'h1E1E1E;
    localparam logic [23:0] INK_RESET   = 24'hDCDDDE;

    localparam logic [15:0] LUMA_WR    = 16'd77;
    localparam logic [15:0] LUMA_WG    = 16'd150;
    localparam logic [15:0] LUMA_WB    = 16'd29;
    localparam logic [15:0] LUMA_RND   = 16'd128;
    localparam logic [15:0] DIV255_MUL = 16'd32897;
    localparam logic [7:0]  ROUND_BIAS = 8'd127;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [1:0]            mode;
    } t_pipe_ctl;

endpackage

@@ hdl/pixel_dark_mode_recolor.sv @@
// Dark mode pixel recolor: pass through, invert, tint or luma remap of an RGBA pixel.
// Request in on i_valid/o_ready with the pixel fields, result out on o_valid/i_ready.
// Configuration by i_cfg_we/i_cfg_idx/i_cfg_data: index 0 mode, 1 paper color,
// 2 ink color; a write lands on the clock edge, no handshake, index 3 is ignored.
// Write configuration only while no pixel is in flight.
// One register stage each holds the luma and tint product, the divide-by-255
// multiply, the ramp multiply, and the mode select with output register.
// Throughput: one pixel per clock while the receiver keeps i_ready high.
// When the receiver stalls, the output holds and earlier stages keep filling
// any empty slots, so o_ready stays high until all four stages hold a pixel.
// Reset (synchronous, active low) empties the pipeline and loads mode pass
// through, paper 0x1E1E1E and ink 0xDCDDDE.
// Depends on pdmr_pkg, pdmr_chan and pixel_dark_mode_recolor_defines.svh.
`include "pixel_dark_mode_recolor_defines.svh"

module pixel_dark_mode_recolor import pdmr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_alpha_in,
    input  logic        i_span_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_alpha_out,
    output logic        o_span_end_out
);

    logic [1:0]            r_mode;
    logic [23:0]           r_paper;
    logic [23:0]           r_ink;
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] stage_en;
    logic [7:0]            r_alpha [NUM_STAGES];
    logic                  r_span  [NUM_STAGES];
    logic [7:0]            r_y1;
    logic [7:0]            r_y2;
    logic [7:0]            r_y3;
    logic [15:0]           luma_acc;
    t_pipe_ctl             pipe_ctl;
    logic [7:0]            chan_in  [3];
    logic [7:0]            chan_out [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PASS;
            r_paper <= PAPER_RESET;
            r_ink   <= INK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_PAPER: r_paper <= i_cfg_data;
                CFG_INK:   r_ink   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
        n_v = r_v;
        if (stage_en[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign luma_acc = 16'(i_red_in) * LUMA_WR + 16'(i_green_in) * LUMA_WG
                    + 16'(i_blue_in) * LUMA_WB + LUMA_RND;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_alpha[0] <= i_alpha_in;
            r_span[0]  <= i_span_end;
            r_y1       <= luma_acc[15:8];
        end
        if (stage_en[1]) begin
            r_y2 <= r_y1;
        end
        if (stage_en[2]) begin
            r_y3 <= r_y2;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                r_alpha[k] <= r_alpha[k-1];
                r_span[k]  <= r_span[k-1];
            end
        end
    end

    assign pipe_ctl.en   = stage_en;
    assign pipe_ctl.mode = r_mode;

    assign chan_in[0] = i_red_in;
    assign chan_in[1] = i_green_in;
    assign chan_in[2] = i_blue_in;

    for (genvar g = 0; g < 3; g++) begin : g_chan
        pdmr_chan u_chan (
            .i_clk   (i_clk),
            .i_ctl   (pipe_ctl),
            .i_c     (chan_in[g]),
            .i_ink   (r_ink[23-8*g -: 8]),
            .i_paper (r_paper[23-8*g -: 8]),
            .i_y1    (r_y1),
            .i_y3    (r_y3),
            .o_res   (chan_out[g])
        );
    end

    assign o_ready        = stage_en[0];
    assign o_valid        = r_v[NUM_STAGES-1];
    assign o_red_out      = chan_out[0];
    assign o_green_out    = chan_out[1];
    assign o_blue_out     = chan_out[2];
    assign o_alpha_out    = r_alpha[NUM_STAGES-1];
    assign o_span_end_out = r_span[NUM_STAGES-1];

    // input only backs up once every stage holds a pixel
    `PDMR_ASSERT_IMPL(a_full_when_blocked, i_clk, i_rst_n, !o_ready, &r_v)
    // a pixel never sits behind an empty output stage
    `PDMR_ASSERT_NEXT(a_no_stuck_bubble, i_clk, i_rst_n, r_v[2] && !r_v[3], r_v[3])

endmodule

@@ hdl/pdmr_chan.sv @@
// four-stage datapath for one color channel: pass, invert, tint and luma remap paths
// depends on pdmr_pkg
module pdmr_chan import pdmr_pkg::*; (
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  logic [7:0]       i_c,
    input  logic [7:0]       i_ink,
    input  logic [7:0]       i_paper,
    input  logic [7:0]       i_y1,
    input  logic [7:0]       i_y3,
    output logic [7:0]       o_res
);

    function automatic logic [7:0] f_clamp(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 12'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic signed [8:0]  d_pi;
    logic signed [8:0]  d_ip;

    // stage 1
    logic        [7:0]  r1_c;
    logic signed [17:0] r1_tv;
    logic signed [17:0] n1_tv;

    // stage 2
    logic        [7:0]  r2_c;
    logic               r2_tneg;
    logic        [31:0] r2_tprod;
    logic signed [17:0] r2_lt;
    logic        [16:0] tmag;
    logic        [31:0] n2_tprod;
    logic signed [17:0] n2_lt;

    // stage 3
    logic        [7:0]  r3_c;
    logic        [7:0]  r3_tint;
    logic signed [9:0]  r3_ls;
    logic signed [11:0] tint_sum;
    logic signed [34:0] lprod;
    logic        [7:0]  n3_tint;
    logic signed [9:0]  n3_ls;

    // stage 4
    logic        [7:0]  r4_res;
    logic signed [11:0] luma_sum;
    logic        [7:0]  n4_res;

    assign d_pi = $signed({1'b0, i_paper}) - $signed({1'b0, i_ink});
    assign d_ip = $signed({1'b0, i_ink}) - $signed({1'b0, i_paper});

    always_comb begin
        n1_tv = $signed({10'd0, i_c}) * $signed({{9{d_pi[8]}}, d_pi})
              + $signed({10'd0, ROUND_BIAS});
    end

    always_comb begin
        // divide by 255 on the magnitude so the quotient truncates toward zero
        tmag     = r1_tv[17] ? 17'(-r1_tv) : r1_tv[16:0];
        n2_tprod = 32'(tmag) * 32'(DIV255_MUL);
        n2_lt    = $signed({10'd0, i_y1}) * $signed({{9{d_ip[8]}}, d_ip})
                 + $signed({10'd0, ROUND_BIAS});
    end

    always_comb begin
        tint_sum = $signed({4'd0, i_ink})
                 + (r2_tneg ? -$signed({4'd0, r2_tprod[30:23]})
                            :  $signed({4'd0, r2_tprod[30:23]}));
        n3_tint  = f_clamp(tint_sum);
        lprod    = $signed({{17{r2_lt[17]}}, r2_lt}) * $signed({19'd0, DIV255_MUL});
        // arithmetic shift by 23, product magnitude stays below 2^32
        n3_ls    = lprod[32:23];
    end

    always_comb begin
        luma_sum = $signed({4'd0, r3_c}) - $signed({4'd0, i_y3})
                 + $signed({4'd0, i_ink}) - $signed({{2{r3_ls[9]}}, r3_ls});
        case (i_ctl.mode)
            MODE_PASS:   n4_res = r3_c;
            MODE_INVERT: n4_res = ~r3_c;
            MODE_TINT:   n4_res = r3_tint;
            MODE_LUMA:   n4_res = f_clamp(luma_sum);
            default:     n4_res = r3_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_c  <= i_c;
            r1_tv <= n1_tv;
        end
        if (i_ctl.en[1]) begin
            r2_c     <= r1_c;
            r2_tneg  <= r1_tv[17];
            r2_tprod <= n2_tprod;
            r2_lt    <= n2_lt;
        end
        if (i_ctl.en[2]) begin
            r3_c    <= r2_c;
            r3_tint <= n3_tint;
            r3_ls   <= n3_ls;
        end
        if (i_ctl.en[3]) begin
            r4_res <= n4_res;
        end
    end

    assign o_res = r4_res;

endmodule

@@ bench/tb_top.sv @@
// testbench for pixel_dark_mode_recolor: random and directed pixels in all four modes,
// results checked against a predictor kept in a small scoreboard class
// depends on pdmr_pkg and the pixel_dark_mode_recolor top level
module tb_top import pdmr_pkg::*; ();

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       span_end;
    } t_pixel;

    class recolor_scoreboard;
        logic [1:0]  mode;
        logic [23:0] paper;
        logic [23:0] ink;
        t_pixel      expected_q[$];
        int          mismatches;

        function new();
            mode       = MODE_PASS;
            paper      = PAPER_RESET;
            ink        = INK_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                CFG_MODE:  mode = data[1:0];
                CFG_PAPER: paper = data;
                CFG_INK:   ink = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] recolor_chan(int c, int luma, int ink_c, int paper_c);
            longint ramp;
            int     v;
            case (mode)
                MODE_INVERT: v = 255 - c;
                // signed int division truncates toward zero
                MODE_TINT:   v = ink_c + (c * (paper_c - ink_c) + int'(ROUND_BIAS)) / 255;
                MODE_LUMA: begin
                    // divide by 255 through a multiply and a flooring shift
                    ramp = (longint'(luma * (ink_c - paper_c) + int'(ROUND_BIAS))
                            * longint'(DIV255_MUL)) >>> 23;
                    v = c - luma + ink_c - int'(ramp);
                end
                default:     v = c;
            endcase
            if (v < 0) begin
                v = 0;
            end else if (v > 255) begin
                v = 255;
            end
            return v[7:0];
        endfunction

        function void note_request(t_pixel px);
            t_pixel exp_px;
            int     luma;
            luma = (int'(LUMA_WR) * int'(px.red) + int'(LUMA_WG) * int'(px.green)
                    + int'(LUMA_WB) * int'(px.blue) + int'(LUMA_RND)) >> 8;
            exp_px.red      = recolor_chan(int'(px.red), luma, int'(ink[23:16]),
                                           int'(paper[23:16]));
            exp_px.green    = recolor_chan(int'(px.green), luma, int'(ink[15:8]),
                                           int'(paper[15:8]));
            exp_px.blue     = recolor_chan(int'(px.blue), luma, int'(ink[7:0]),
                                           int'(paper[7:0]));
            exp_px.alpha    = px.alpha;
            exp_px.span_end = px.span_end;
            expected_q.push_back(exp_px);
        endfunction

        function void check_result(t_pixel got);
            t_pixel want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: r=%0d g=%0d b=%0d a=%0d end=%0d",
                             got.red, got.green, got.blue, got.alpha, got.span_end);
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                    || got.alpha !== want.alpha || got.span_end !== want.span_end) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch mode=%0d: expected r=%0d g=%0d b=%0d a=%0d end=%0d",
                             mode, want.red, want.green, want.blue, want.alpha,
                             want.span_end);
                    $display("    got r=%0d g=%0d b=%0d a=%0d end=%0d",
                             got.red, got.green, got.blue, got.alpha, got.span_end);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit clean();
            return mismatches == 0 && expected_q.size() == 0;
        endfunction
    endclass

    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = NUM_STAGES + 4;
    localparam int SQUEEZE_AT     = 500;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 116;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic [7:0]  i_alpha_in = '0;
    logic        i_span_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_alpha_out;
    logic        o_span_end_out;

    recolor_scoreboard sb;
    bit  steady = 1'b0;
    bit  squeezed = 1'b0;
    int  squeeze_left = 0;
    int  requests_in = 0;
    int  quiet_cycles = 0;

    pixel_dark_mode_recolor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_alpha_in     (i_alpha_in),
        .i_span_end     (i_span_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_alpha_out    (o_alpha_out),
        .o_span_end_out (o_span_end_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function bit idle_roll();
        return !steady && ($urandom_range(99) < 8);
    endfunction

    function logic [7:0] pick_chan();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [23:0] random_color();
        case ($urandom_range(5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return {pick_chan(), pick_chan(), pick_chan()};
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver side, with one long hold-off once the block is well into the stream
    always @(negedge i_clk) begin
        if (squeeze_left != 0) begin
            i_ready <= 1'b0;
            squeeze_left <= squeeze_left - 1;
        end else if (!squeezed && requests_in == SQUEEZE_AT) begin
            i_ready <= 1'b0;
            squeeze_left <= SQUEEZE_CYCLES - 1;
            squeezed <= 1'b1;
        end else begin
            i_ready <= !idle_roll();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_request({i_red_in, i_green_in, i_blue_in, i_alpha_in, i_span_end});
                requests_in <= requests_in + 1;
            end
            if (o_valid && i_ready)
                sb.check_result({o_red_out, o_green_out, o_blue_out, o_alpha_out,
                                 o_span_end_out});
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_pixel(t_pixel px);
        while (idle_roll()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_red_in, i_green_in, i_blue_in, i_alpha_in, i_span_end} <= px;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic s);
        send_pixel({r, g, b, a, s});
    endtask

    // stop offering and let the pipeline empty out
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic reconfigure(logic [23:0] mode_word, logic [23:0] paper_word,
                               logic [23:0] ink_word, bit poke_spare);
        settle();
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_PAPER, paper_word);
        write_reg(CFG_INK, ink_word);
        if (poke_spare)
            write_reg(CFG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [1:0] mode_sel;
        int         p;
        int         n;
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: pass through
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_rgba(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);

        // upper bits of the mode word are dropped
        reconfigure({22'h3FFFFF, MODE_INVERT}, PAPER_RESET, INK_RESET, 1'b0);
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_rgba(8'h12, 8'h80, 8'hED, 8'h7F, 1'b0);

        reconfigure({22'h0, MODE_TINT}, PAPER_RESET, INK_RESET, 1'b0);
        send_rgba(8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b1);
        send_rgba(8'h80, 8'h7F, 8'h01, 8'h80, 1'b0);
        reconfigure({22'h2AAAAA, MODE_TINT}, 24'hFFFFFF, 24'h000000, 1'b0);
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        reconfigure({22'h155555, MODE_TINT}, 24'h000000, 24'hFFFFFF, 1'b0);
        send_rgba(8'hFF, 8'h00, 8'h80, 8'h40, 1'b0);

        // luma remap with both ramp directions, saturating at 255 in the first
        reconfigure({22'h0, MODE_LUMA}, 24'h000000, 24'hFFFFFF, 1'b0);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_rgba(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        send_rgba(8'hFF, 8'h00, 8'h00, 8'h33, 1'b0);
        send_rgba(8'h00, 8'h00, 8'hFF, 8'hCC, 1'b1);
        // write to the unused index must leave the registers alone
        reconfigure({22'h3FFFFF, MODE_LUMA}, 24'hFFFFFF, 24'h000000, 1'b1);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_rgba(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        reconfigure({22'h0, MODE_LUMA}, PAPER_RESET, INK_RESET, 1'b0);
        send_rgba(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
        send_rgba(8'hFF, 8'h00, 8'hFF, 8'h01, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            mode_sel = 2'(p);
            reconfigure({22'($urandom), mode_sel}, random_color(), random_color(),
                        1'($urandom_range(1)));
            steady = (p == 5);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_pixel({pick_chan(), pick_chan(), pick_chan(), 8'($urandom),
                            1'($urandom_range(1))});
        end
        steady = 1'b0;

        settle();
        if (sb.clean()) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
